// ===== hw/rtl/tkc_pkg.sv =====
package tkc_pkg;

    // Converter front end: ADC code to millivolts in signed Q7.16.
    localparam int ADC_FULL_SCALE = 4095;
    localparam int IN_W   = 12;
    localparam int CJ_W   = 12;
    localparam int TEMP_W = 16;

    localparam longint MV_VREF  = 3300;
    localparam longint MV_OFF   = 350 * ADC_FULL_SCALE;
    localparam longint MV_SCALE = 100 * 65536;
    localparam longint MV_DEN   = 5416 * ADC_FULL_SCALE;
    localparam longint MV_HALF  = MV_DEN / 2;

    // Scaled magnitudes stay below 2**MV_XW over the whole full-scale range.
    localparam int MV_XW = 48;
    localparam int MV_XH = MV_XW / 2;
    localparam longint MV_RCP = (longint'(1) << MV_XW) / MV_DEN;
    localparam int MV_RW = $clog2(MV_RCP + 1);
    localparam int MV_PW = MV_XH + MV_RW;

    localparam longint MV_CODE_MAX = ((longint'(1) << IN_W) - 1) * MV_VREF;
    localparam int MV_MAGW = ($clog2(MV_CODE_MAX + 1) > $clog2(MV_OFF + 1)) ?
                             $clog2(MV_CODE_MAX + 1) : $clog2(MV_OFF + 1);
    localparam int MV_NW = MV_MAGW + 1;
    localparam int MV_STAGES = 9;

    // Polynomial ranges in Q7.16 millivolts.
    localparam int MV_W    = 23;
    localparam int MV_LOW  = -424542;
    localparam int MV_MID  = 1352925;
    localparam int MV_HIGH = 3597926;

    // Horner datapath: accumulator in Q.46.
    localparam int FRAC_BITS    = 46;
    localparam int ACC_W        = 64;
    localparam int ACC_HALF     = ACC_W / 2;
    localparam int LP_W         = ACC_HALF + 1 + MV_W;
    localparam int HP_W         = ACC_HALF + MV_W;
    localparam int MUL_SHIFT    = 16;
    localparam int SUM_W        = ACC_W + MUL_SHIFT + 8;
    localparam int RND_HALF     = 1 << (MUL_SHIFT - 1);
    localparam int HORNER_STEPS = 9;
    localparam int COEF_N       = HORNER_STEPS + 1;

    // Final scaling to 1/16 degree.
    localparam int TEMP_SHIFT = FRAC_BITS - 4;
    localparam int T_W        = ACC_W - TEMP_SHIFT + 2;
    localparam int TEMP_MIN   = -8192;
    localparam int TEMP_MAX   = 32767;

    typedef enum logic [1:0] {
        SEG_NEG,
        SEG_MID,
        SEG_HIGH
    } tkc_seg_t;

    typedef struct packed {
        logic                    vld;
        logic                    oor;
        tkc_seg_t                seg;
        logic signed [MV_W-1:0]  mv;
        logic signed [CJ_W-1:0]  cj;
    } tkc_mv_t;

    typedef struct packed {
        logic                    oor;
        tkc_seg_t                seg;
        logic signed [MV_W-1:0]  mv;
        logic signed [CJ_W-1:0]  cj;
        logic                    neg;
        logic signed [LP_W-1:0]  lp;
        logic signed [HP_W-1:0]  hp;
    } tkc_hmul_t;

    typedef struct packed {
        logic                    oor;
        tkc_seg_t                seg;
        logic signed [MV_W-1:0]  mv;
        logic signed [CJ_W-1:0]  cj;
        logic signed [ACC_W-1:0] acc;
    } tkc_hacc_t;

    typedef struct packed {
        logic                    vld;
        logic                    oor;
        logic signed [CJ_W-1:0]  cj;
        logic signed [ACC_W-1:0] acc;
    } tkc_acc_t;

    // Decimal coefficient mant * 10**-e10 as Q.46, rounded half away from zero.
    // Long division by shift and subtract; used for constants only.
    function automatic logic signed [ACC_W-1:0] coef_q(input int mant, input int e10);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] q;
        d = 64'd1;
        for (int i = 0; i < e10; i++) begin
            d = d * 64'd10;
        end
        m = (mant < 0) ? 64'(-mant) : 64'(mant);
        r = '0;
        q = '0;
        for (int i = 31; i >= 0; i--) begin
            r = {r[62:0], m[i]};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = {r[62:0], 1'b0};
            q = {q[62:0], 1'b0};
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        r = {r[62:0], 1'b0};
        if (r >= d) begin
            q = q + 64'd1;
        end
        return (mant < 0) ? -$signed(q) : $signed(q);
    endfunction

    localparam logic signed [ACC_W-1:0] COEF_NEG [COEF_N] = '{
        coef_q(0, 0), coef_q(25173462, 6), coef_q(-11662878, 7), coef_q(-10833638, 7),
        coef_q(-89773540, 8), coef_q(-37342377, 8), coef_q(-86632643, 9),
        coef_q(-10450598, 9), coef_q(-51920577, 11), coef_q(0, 0)
    };

    localparam logic signed [ACC_W-1:0] COEF_MID [COEF_N] = '{
        coef_q(0, 0), coef_q(2508355, 5), coef_q(7860106, 8), coef_q(-2503131, 7),
        coef_q(8315270, 8), coef_q(-1228034, 8), coef_q(9804036, 10),
        coef_q(-4413030, 11), coef_q(1057734, 12), coef_q(-1052755, 14)
    };

    localparam logic signed [ACC_W-1:0] COEF_HIGH [COEF_N] = '{
        coef_q(-1318058, 4), coef_q(4830222, 5), coef_q(-1646031, 6), coef_q(5464731, 8),
        coef_q(-9650715, 10), coef_q(8802193, 12), coef_q(-3110810, 14),
        coef_q(0, 0), coef_q(0, 0), coef_q(0, 0)
    };

    function automatic logic signed [ACC_W-1:0] coef_pick(input tkc_seg_t seg,
                                                          input logic [3:0] idx);
        logic signed [ACC_W-1:0] c;
        case (seg)
            SEG_NEG: c = COEF_NEG[idx];
            SEG_MID: c = COEF_MID[idx];
            default: c = COEF_HIGH[idx];
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/tkc_mv.sv =====
module tkc_mv (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [tkc_pkg::IN_W-1:0]             adc_code,
    input  logic signed [tkc_pkg::CJ_W-1:0]      cold_junction,
    output tkc_pkg::tkc_mv_t                     mv_out
);

    logic [tkc_pkg::MV_STAGES-1:0]         v_reg;
    logic signed [tkc_pkg::CJ_W-1:0]       cj_reg [tkc_pkg::MV_STAGES];
    // Sign of the offset-corrected code, carried from stage 2 to stage 7.
    logic [5:0]                            neg_reg;

    logic signed [tkc_pkg::MV_NW-1:0]      n1_reg, n1_next;
    logic [tkc_pkg::MV_MAGW-1:0]           mag2_reg, mag2_next;
    logic [tkc_pkg::MV_XW-1:0]             x3_reg, x3_next;
    logic [tkc_pkg::MV_XW-1:0]             x4_reg, x5_reg, x6_reg;
    logic [tkc_pkg::MV_PW-1:0]             ph4_reg, ph4_next;
    logic [tkc_pkg::MV_PW-1:0]             pl4_reg, pl4_next;
    logic [tkc_pkg::MV_PW:0]               q5_sum;
    logic [tkc_pkg::MV_RW-1:0]             q5_reg, q5_next;
    logic [tkc_pkg::MV_RW-1:0]             q6_reg;
    logic [tkc_pkg::MV_XW-1:0]             qd6_reg, qd6_next;
    logic [tkc_pkg::MV_XW-1:0]             r7;
    logic [tkc_pkg::MV_RW-1:0]             q7_reg, q7_next;
    logic signed [tkc_pkg::MV_RW:0]        mv8_reg, mv8_next;
    logic signed [31:0]                    mv_ext;
    logic                                  oor9_reg, oor9_next;
    tkc_pkg::tkc_seg_t                     seg9_reg, seg9_next;
    logic signed [tkc_pkg::MV_W-1:0]       mv9_reg, mv9_next;

    always_comb begin
        n1_next   = tkc_pkg::MV_NW'(adc_code) * tkc_pkg::MV_NW'(tkc_pkg::MV_VREF)
                    - tkc_pkg::MV_NW'(tkc_pkg::MV_OFF);
        mag2_next = tkc_pkg::MV_MAGW'(n1_reg[tkc_pkg::MV_NW-1] ? -n1_reg : n1_reg);
        // Magnitude scaled to Q16 plus half the divisor, for rounding half away.
        x3_next   = tkc_pkg::MV_XW'(mag2_reg) * tkc_pkg::MV_XW'(tkc_pkg::MV_SCALE)
                    + tkc_pkg::MV_XW'(tkc_pkg::MV_HALF);
        // Quotient estimate by the truncated reciprocal, in two partial products.
        ph4_next  = tkc_pkg::MV_PW'(x3_reg[tkc_pkg::MV_XW-1:tkc_pkg::MV_XH])
                    * tkc_pkg::MV_PW'(tkc_pkg::MV_RCP);
        pl4_next  = tkc_pkg::MV_PW'(x3_reg[tkc_pkg::MV_XH-1:0])
                    * tkc_pkg::MV_PW'(tkc_pkg::MV_RCP);
        q5_sum    = {1'b0, ph4_reg} + {1'b0, pl4_reg >> tkc_pkg::MV_XH};
        q5_next   = tkc_pkg::MV_RW'(q5_sum >> tkc_pkg::MV_XH);
        qd6_next  = tkc_pkg::MV_XW'(q5_reg) * tkc_pkg::MV_XW'(tkc_pkg::MV_DEN);
        // The estimate is low by at most one; the remainder settles it.
        r7        = x6_reg - qd6_reg;
        q7_next   = q6_reg + tkc_pkg::MV_RW'(r7 >= tkc_pkg::MV_XW'(tkc_pkg::MV_DEN));
        mv8_next  = neg_reg[5] ? -$signed({1'b0, q7_reg}) : $signed({1'b0, q7_reg});
        mv_ext    = 32'(mv8_reg);
        oor9_next = (mv_ext < tkc_pkg::MV_LOW) || (mv_ext > tkc_pkg::MV_HIGH);
        if (mv_ext < 0) begin
            seg9_next = tkc_pkg::SEG_NEG;
        end else if (mv_ext <= tkc_pkg::MV_MID) begin
            seg9_next = tkc_pkg::SEG_MID;
        end else begin
            seg9_next = tkc_pkg::SEG_HIGH;
        end
        mv9_next  = tkc_pkg::MV_W'(mv_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[tkc_pkg::MV_STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cj_reg[0] <= cold_junction;
            for (int i = 1; i < tkc_pkg::MV_STAGES; i++) begin
                cj_reg[i] <= cj_reg[i-1];
            end
            neg_reg  <= {neg_reg[4:0], n1_reg[tkc_pkg::MV_NW-1]};
            n1_reg   <= n1_next;
            mag2_reg <= mag2_next;
            x3_reg   <= x3_next;
            x4_reg   <= x3_reg;
            ph4_reg  <= ph4_next;
            pl4_reg  <= pl4_next;
            x5_reg   <= x4_reg;
            q5_reg   <= q5_next;
            x6_reg   <= x5_reg;
            q6_reg   <= q5_reg;
            qd6_reg  <= qd6_next;
            q7_reg   <= q7_next;
            mv8_reg  <= mv8_next;
            oor9_reg <= oor9_next;
            seg9_reg <= seg9_next;
            mv9_reg  <= mv9_next;
        end
    end

    assign mv_out = '{
        vld: v_reg[tkc_pkg::MV_STAGES-1],
        oor: oor9_reg,
        seg: seg9_reg,
        mv:  mv9_reg,
        cj:  cj_reg[tkc_pkg::MV_STAGES-1]
    };

endmodule

// ===== hw/rtl/tkc_horner.sv =====
module tkc_horner (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  tkc_pkg::tkc_mv_t  mv_in,
    output tkc_pkg::tkc_acc_t acc_out
);

    logic                 a_vld_reg [tkc_pkg::HORNER_STEPS];
    logic                 b_vld_reg [tkc_pkg::HORNER_STEPS];
    tkc_pkg::tkc_hmul_t   a_reg     [tkc_pkg::HORNER_STEPS];
    tkc_pkg::tkc_hacc_t   b_reg     [tkc_pkg::HORNER_STEPS];

    // Each step is a multiply stage and a round-and-add stage. Every segment
    // runs all steps; missing high-order terms are zero coefficients.
    for (genvar k = 0; k < tkc_pkg::HORNER_STEPS; k++) begin : g_step
        tkc_pkg::tkc_hacc_t             src;
        logic                           src_vld;
        tkc_pkg::tkc_hmul_t             a_next;
        tkc_pkg::tkc_hacc_t             b_next;
        logic signed [tkc_pkg::ACC_W-1:0] coef;
        logic [tkc_pkg::SUM_W-1:0]      sum;

        if (k == 0) begin : g_first
            assign src_vld = mv_in.vld;
            assign src = '{
                oor: mv_in.oor,
                seg: mv_in.seg,
                mv:  mv_in.mv,
                cj:  mv_in.cj,
                acc: tkc_pkg::coef_pick(mv_in.seg, 4'(tkc_pkg::HORNER_STEPS))
            };
        end else begin : g_next
            assign src_vld = b_vld_reg[k-1];
            assign src     = b_reg[k-1];
        end

        assign coef = tkc_pkg::coef_pick(a_reg[k].seg, 4'(tkc_pkg::HORNER_STEPS - 1 - k));

        always_comb begin
            a_next.oor = src.oor;
            a_next.seg = src.seg;
            a_next.mv  = src.mv;
            a_next.cj  = src.cj;
            // Sign of the full product decides the rounding offset.
            a_next.neg = src.acc[tkc_pkg::ACC_W-1] ^ src.mv[tkc_pkg::MV_W-1];
            a_next.lp  = $signed({1'b0, src.acc[tkc_pkg::ACC_HALF-1:0]}) * src.mv;
            a_next.hp  = $signed(src.acc[tkc_pkg::ACC_W-1:tkc_pkg::ACC_HALF]) * src.mv;
        end

        always_comb begin
            // Coefficient enters above the dropped bits, so one shift gives
            // the rounded product plus the coefficient.
            sum = (tkc_pkg::SUM_W'(a_reg[k].hp) <<< tkc_pkg::ACC_HALF)
                  + tkc_pkg::SUM_W'(a_reg[k].lp)
                  + (tkc_pkg::SUM_W'(coef) <<< tkc_pkg::MUL_SHIFT)
                  + tkc_pkg::SUM_W'(tkc_pkg::RND_HALF)
                  - tkc_pkg::SUM_W'(a_reg[k].neg);
            b_next.oor = a_reg[k].oor;
            b_next.seg = a_reg[k].seg;
            b_next.mv  = a_reg[k].mv;
            b_next.cj  = a_reg[k].cj;
            b_next.acc = sum[tkc_pkg::ACC_W+tkc_pkg::MUL_SHIFT-1:tkc_pkg::MUL_SHIFT];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                a_vld_reg[k] <= 1'b0;
                b_vld_reg[k] <= 1'b0;
            end else if (en) begin
                a_vld_reg[k] <= src_vld;
                b_vld_reg[k] <= a_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[k] <= a_next;
                b_reg[k] <= b_next;
            end
        end
    end

    assign acc_out = '{
        vld: b_vld_reg[tkc_pkg::HORNER_STEPS-1],
        oor: b_reg[tkc_pkg::HORNER_STEPS-1].oor,
        cj:  b_reg[tkc_pkg::HORNER_STEPS-1].cj,
        acc: b_reg[tkc_pkg::HORNER_STEPS-1].acc
    };

endmodule

// ===== hw/rtl/type_k_thermocouple_to_celsius_top.sv =====
// Pipeline: an accepted item passes 9 stages of millivolt conversion, then 18
// for the nine Horner multiply/add steps, then the output register to m_tvalid.
// Throughput: one item per cycle while the pipeline is not held.
// The whole pipeline advances together; it holds only when the output register
// is full, not taken, and the last Horner stage carries an item.
// Reset clears the valid bits only; no data is cleared.
module type_k_thermocouple_to_celsius_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] adc_code, [23:12] cold_junction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] temperature
    output logic        m_tuser    // [0] out_of_range
);

    logic                                en;
    logic                                out_load;
    tkc_pkg::tkc_mv_t                    mv_item;
    tkc_pkg::tkc_acc_t                   acc_item;
    logic signed [tkc_pkg::T_W-1:0]      t_sum;
    logic [tkc_pkg::TEMP_W-1:0]          temp_next;
    logic                                m_tvalid_reg;
    logic [tkc_pkg::TEMP_W-1:0]          temp_reg;
    logic                                oor_reg;

    assign out_load = !m_tvalid_reg || m_tready;
    assign en       = out_load || !acc_item.vld;
    assign s_tready = en;

    tkc_mv u_mv (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_vld        (s_tvalid),
        .adc_code      (s_tdata[11:0]),
        .cold_junction (s_tdata[23:12]),
        .mv_out        (mv_item)
    );

    tkc_horner u_horner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .mv_in   (mv_item),
        .acc_out (acc_item)
    );

    always_comb begin
        // Round Q.46 to 1/16 degree, then add the cold junction.
        t_sum = tkc_pkg::T_W'($signed(acc_item.acc[tkc_pkg::ACC_W-1:tkc_pkg::TEMP_SHIFT]))
                + tkc_pkg::T_W'({1'b0, acc_item.acc[tkc_pkg::TEMP_SHIFT-1]})
                + tkc_pkg::T_W'(acc_item.cj);
        if (acc_item.oor) begin
            temp_next = '0;
        end else if (t_sum < tkc_pkg::TEMP_MIN) begin
            temp_next = tkc_pkg::TEMP_W'(tkc_pkg::TEMP_MIN);
        end else if (t_sum > tkc_pkg::TEMP_MAX) begin
            temp_next = tkc_pkg::TEMP_W'(tkc_pkg::TEMP_MAX);
        end else begin
            temp_next = tkc_pkg::TEMP_W'(t_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= acc_item.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && acc_item.vld) begin
            temp_reg <= temp_next;
            oor_reg  <= acc_item.oor;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = temp_reg;
    assign m_tuser  = oor_reg;

endmodule

// ===== dv/tkc_checker.sv =====
`timescale 1ns / 100ps

module tkc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] adc_code, [23:12] cold_junction
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] temperature
    input  logic        m_tuser,   // [0] out_of_range
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic signed [15:0] temperature;
        logic               out_of_range;
    } tc_result_t;

    localparam longint FULL_SCALE   = 4095;
    localparam longint MV_DIVISOR   = 5416 * FULL_SCALE;
    localparam longint MV_FLOOR     = -424542;
    localparam longint MV_KNEE      = 1352925;
    localparam longint MV_CEIL      = 3597926;
    localparam longint DEG16_MIN    = -8192;
    localparam longint DEG16_MAX    = 32767;
    localparam int     Q_FRAC       = 46;
    localparam int     MAX_REPORTS  = 10;

    // Inverse polynomial coefficients as mantissa * 10**-exponent, one row per segment.
    localparam int POLY_MANT [3][10] = '{
        '{0, 25173462, -11662878, -10833638, -89773540,
          -37342377, -86632643, -10450598, -51920577, 0},
        '{0, 2508355, 7860106, -2503131, 8315270,
          -1228034, 9804036, -4413030, 1057734, -1052755},
        '{-1318058, 4830222, -1646031, 5464731, -9650715,
          8802193, -3110810, 0, 0, 0}
    };
    localparam int POLY_EXP [3][10] = '{
        '{0, 6, 7, 7, 8, 8, 9, 9, 11, 0},
        '{0, 5, 8, 7, 8, 8, 10, 11, 12, 14},
        '{4, 5, 6, 8, 10, 12, 14, 0, 0, 0}
    };
    localparam int POLY_DEGREE [3] = '{8, 9, 6};

    longint     poly_q46 [3][10];
    tc_result_t pending_temps [$];
    tc_result_t oldest;
    int         mismatches;

    function automatic longint decimal_to_q46(input int mant, input int exp10);
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] quo;
        logic [63:0] rem;
        den = 64'd1;
        repeat (exp10) den = den * 64'd10;
        mag = (mant < 0) ? 64'(-longint'(mant)) : 64'(mant);
        quo = mag / den;
        rem = mag % den;
        for (int i = 0; i < Q_FRAC; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        rem = rem << 1;
        if (rem >= den) begin
            quo = quo + 64'd1;
        end
        return (mant < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // Q16 product rounded half away from zero; the magnitude saturates the way
    // a 64-bit truncation of the 128-bit product would.
    function automatic longint q16_product(input longint a, input longint b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic         neg;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = 128'(ua) * 128'(ub) + 128'h8000;
        if (prod[127:111] != '0) begin
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            mag = prod[79:16];
        end
        if (mag[63]) begin
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic tc_result_t convert_sample(input logic [11:0] adc,
                                                  input logic signed [11:0] cj);
        tc_result_t       res;
        longint           num;
        longint           mv;
        longint           acc;
        longint           deg16;
        logic [63:0]      biased;
        tkc_pkg::tkc_seg_t seg;
        int               row;
        num = (longint'(adc) * 3300 - 350 * FULL_SCALE) * 100 * 65536;
        if (num >= 0) begin
            mv = (num + MV_DIVISOR / 2) / MV_DIVISOR;
        end else begin
            mv = -((-num + MV_DIVISOR / 2) / MV_DIVISOR);
        end
        if (mv < MV_FLOOR || mv > MV_CEIL) begin
            res.temperature  = '0;
            res.out_of_range = 1'b1;
            return res;
        end
        if (mv < 0) begin
            seg = tkc_pkg::SEG_NEG;
        end else if (mv <= MV_KNEE) begin
            seg = tkc_pkg::SEG_MID;
        end else begin
            seg = tkc_pkg::SEG_HIGH;
        end
        row = int'(seg);
        acc = poly_q46[row][POLY_DEGREE[row]];
        for (int i = POLY_DEGREE[row]; i > 0; i--) begin
            acc = q16_product(acc, mv) + poly_q46[row][i-1];
        end
        // Round Q.46 degrees to 1/16 degree, floor after adding half.
        biased = 64'(acc) + (64'd1 << 41) + (64'd1 << 62);
        deg16  = longint'(biased >> 42) - (longint'(1) << 20);
        deg16  = deg16 + longint'(cj);
        if (deg16 < DEG16_MIN) deg16 = DEG16_MIN;
        if (deg16 > DEG16_MAX) deg16 = DEG16_MAX;
        res.temperature  = 16'(deg16);
        res.out_of_range = 1'b0;
        return res;
    endfunction

    initial begin
        for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < 10; k++) begin
                poly_q46[s][k] = decimal_to_q46(POLY_MANT[s][k], POLY_EXP[s][k]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            mismatches = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_temps.push_back(convert_sample(s_tdata[11:0], s_tdata[23:12]));
            end
            if (m_tvalid && m_tready) begin
                if (pending_temps.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: result item with none predicted: temp %0d oor %0b",
                                 $realtime, $signed(m_tdata), m_tuser);
                    end
                    mismatches++;
                end else begin
                    oldest = pending_temps.pop_front();
                    if (m_tdata !== oldest.temperature || m_tuser !== oldest.out_of_range) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("%0t: expected temp %0d oor %0b, got temp %0d oor %0b",
                                     $realtime, oldest.temperature, oldest.out_of_range,
                                     $signed(m_tdata), m_tuser);
                        end
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        pending    <= pending_temps.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 220;
    localparam int DRAIN_CYCLES = 40;
    localparam int ZERO_MV_CODE = 434;
    localparam int KNEE_CODE = 1822;

    localparam logic [11:0] DIR_ADC [18] = '{
        12'd0, 12'd4095, 12'd1, 12'd4094, 12'd432, 12'd433, 12'd434, 12'd435,
        12'd436, 12'd1820, 12'd1821, 12'd1822, 12'd1823, 12'd1824, 12'd2047,
        12'd2048, 12'd1365, 12'd2730
    };
    localparam logic [11:0] DIR_CJ [6] = '{
        12'h800, 12'h7FF, 12'h000, 12'hD80, 12'hFFF, 12'h001
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    type_k_thermocouple_to_celsius_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tkc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver takes a long hold-off when one is requested, else stalls at random.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                rx_stall_pct    = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 81;
                rx_stall_pct    = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                rx_stall_pct    = 81;
            end
            default: begin
                sender_idle_pct = 13;
                rx_stall_pct    = 13;
            end
        endcase
    endtask

    task automatic push_sample(input logic [11:0] adc, input logic [11:0] cj);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cj, adc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Codes near zero millivolts and the segment knee are drawn more often.
    task automatic push_random_sample();
        int          pick;
        logic [11:0] adc;
        pick = $urandom_range(9);
        if (pick == 0) begin
            adc = 12'(ZERO_MV_CODE - 8 + $urandom_range(16));
        end else if (pick == 1) begin
            adc = 12'(KNEE_CODE - 8 + $urandom_range(16));
        end else begin
            adc = 12'($urandom_range(4095));
        end
        push_sample(adc, 12'($urandom_range(4095)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 18; i++) begin
            push_sample(DIR_ADC[i], DIR_CJ[i % 6]);
        end
        drain_results();

        for (int round = 0; round < 2; round++) begin
            for (int m = 0; m < 4; m++) begin
                set_idle_mode(idle_mode_t'(m));
                repeat (PHASE_ITEMS) push_random_sample();
                drain_results();
            end
        end

        // Long receiver hold-off while the sender keeps offering items.
        set_idle_mode(IDLE_NONE);
        rx_hold_req = 300;
        repeat (60) push_random_sample();
        drain_results();

        set_idle_mode(IDLE_BOTH);
        repeat (130) push_random_sample();
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
